// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion held off while reset is asserted
`define LKW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// assertion checked at every edge, reset included
`define LKW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== design/lkw_pkg.sv =====
// ----------------------------------------------------------------------------
// lkw_pkg
// types and constants of the link keepalive watchdog
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkw_pkg;

  localparam int NOW_W      = 32;
  localparam int INTV_W     = 16;
  localparam int REINIT_W   = 8;
  localparam int COUNT_W    = 16;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [INTV_W-1:0]   PING_INTV_RST   = 16'd4000;
  localparam logic [INTV_W-1:0]   DISC_INTV_RST   = 16'd6000;
  localparam logic [REINIT_W-1:0] REINIT_AT_RST   = 8'd3;
  localparam logic                REINIT_EN_RST   = 1'b1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POLL      = 2'd0,
    FUNC_RX_SEEN   = 2'd1,
    FUNC_HANDSHAKE = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PING_INTV = 8'd0,
    REG_DISC_INTV = 8'd1,
    REG_REINIT_AT = 8'd2,
    REG_REINIT_EN = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [INTV_W-1:0]   ping_interval;
    logic [INTV_W-1:0]   disconnect_interval;
    logic [REINIT_W-1:0] reinit_at_count;
    logic                reinit_enable;
  } cfg_t;

  typedef struct packed {
    logic               connected;
    logic               send_status_request;
    logic               flush_receive;
    logic               reinit_link;
    logic [COUNT_W-1:0] timeout_number;
  } result_t;

endpackage

// ===== design/lkw_ifs.sv =====
// ----------------------------------------------------------------------------
// lkw channel interfaces
// input, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lkw_in_if;
  import lkw_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NOW_W-1:0]  now_ms;
  modport source (output valid, output func, output now_ms, input ready);
  modport sink   (input valid, input func, input now_ms, output ready);
endinterface

interface lkw_out_if;
  import lkw_pkg::*;
  logic               valid;
  logic               ready;
  logic               connected;
  logic               send_status_request;
  logic               flush_receive;
  logic               reinit_link;
  logic [COUNT_W-1:0] timeout_number;
  modport source (output valid, output connected, output send_status_request,
                  output flush_receive, output reinit_link, output timeout_number,
                  input ready);
  modport sink   (input valid, input connected, input send_status_request,
                  input flush_receive, input reinit_link, input timeout_number,
                  output ready);
endinterface

interface lkw_cfg_if;
  import lkw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/link_keepalive_watchdog.sv =====
// ----------------------------------------------------------------------------
// link_keepalive_watchdog
// keepalive watchdog for a serial link: polls, receive activity and
// handshake notices in, one connection verdict with requests out per item
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    func, now_ms
//   out_ch    out  valid/ready    connected, send_status_request,
//                                 flush_receive, reinit_link, timeout_number
//   cfg_ch    in   valid/ready    index, data (ready always high)
//
// one item per cycle while the result channel is not stalled; items pass
// from input register to result register, with the watchdog state updated
// as an item leaves the input register
// reset: synchronous, rst_n low; no clearing pass
// a stalled result holds the result register; the input register keeps
// accepting while the result register is free or being taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_keepalive_watchdog (
  input  logic      clk,
  input  logic      rst_n,
  lkw_in_if.sink    in_ch,
  lkw_out_if.source out_ch,
  lkw_cfg_if.sink   cfg_ch
);
  import lkw_pkg::*;

  cfg_t             cfg;
  result_t          core_res;
  logic             advance;

  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [NOW_W-1:0]  s1_now_r;
  logic              out_valid_r;
  result_t           out_res_r;

  assign cfg_ch.ready = 1'b1;

  lkw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid && cfg_ch.ready),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  lkw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance && s1_valid_r),
    .func   (s1_func_r),
    .now_ms (s1_now_r),
    .cfg    (cfg),
    .res    (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_func_r <= in_ch.func;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.connected           = out_res_r.connected;
  assign out_ch.send_status_request = out_res_r.send_status_request;
  assign out_ch.flush_receive       = out_res_r.flush_receive;
  assign out_ch.reinit_link         = out_res_r.reinit_link;
  assign out_ch.timeout_number      = out_res_r.timeout_number;

endmodule

// ===== design/lkw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lkw_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkw_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [lkw_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [lkw_pkg::CFG_DATA_W-1:0] wr_data,
  output lkw_pkg::cfg_t                 cfg
);
  import lkw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_PING_INTV: cfg_nxt.ping_interval       = wr_data[INTV_W-1:0];
        REG_DISC_INTV: cfg_nxt.disconnect_interval = wr_data[INTV_W-1:0];
        REG_REINIT_AT: cfg_nxt.reinit_at_count     = wr_data[REINIT_W-1:0];
        REG_REINIT_EN: cfg_nxt.reinit_enable       = wr_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ping_interval       <= PING_INTV_RST;
      cfg_r.disconnect_interval <= DISC_INTV_RST;
      cfg_r.reinit_at_count     <= REINIT_AT_RST;
      cfg_r.reinit_enable       <= REINIT_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/lkw_core.sv =====
// ----------------------------------------------------------------------------
// lkw_core
// watchdog state and per-item decision logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkw_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [lkw_pkg::FUNC_W-1:0] func,
  input  logic [lkw_pkg::NOW_W-1:0]  now_ms,
  input  lkw_pkg::cfg_t             cfg,
  output lkw_pkg::result_t          res
);
  import lkw_pkg::*;

  logic               start_pending_r, start_pending_nxt;
  logic               skip_first_ping_r, skip_first_ping_nxt;
  logic [NOW_W-1:0]   ping_deadline_r, ping_deadline_nxt;
  logic [NOW_W-1:0]   disc_deadline_r, disc_deadline_nxt;
  logic [COUNT_W-1:0] timeout_count_r, timeout_count_nxt;

  logic [NOW_W-1:0]   ping_ext, disc_ext;
  logic [NOW_W-1:0]   ping_next_dl, disc_next_dl, first_disc_dl;
  logic [NOW_W-1:0]   disc_diff, ping_diff;
  logic               disc_passed, ping_passed;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    ping_ext      = {{(NOW_W-INTV_W){1'b0}}, cfg.ping_interval};
    disc_ext      = {{(NOW_W-INTV_W){1'b0}}, cfg.disconnect_interval};
    ping_next_dl  = now_ms + ping_ext;
    disc_next_dl  = now_ms + disc_ext;
    first_disc_dl = disc_next_dl - ping_ext;
    disc_diff     = now_ms - disc_deadline_r;
    ping_diff     = now_ms - ping_deadline_r;
    disc_passed   = !disc_diff[NOW_W-1];
    ping_passed   = !ping_diff[NOW_W-1];
    count_inc     = (timeout_count_r == COUNT_MAX) ? timeout_count_r
                                                   : timeout_count_r + 1'b1;

    start_pending_nxt   = start_pending_r;
    skip_first_ping_nxt = skip_first_ping_r;
    ping_deadline_nxt   = ping_deadline_r;
    disc_deadline_nxt   = disc_deadline_r;
    timeout_count_nxt   = timeout_count_r;
    res                 = '0;

    case (func_t'(func))
      FUNC_POLL: begin
        if (start_pending_r) begin
          start_pending_nxt   = 1'b0;
          disc_deadline_nxt   = first_disc_dl;
          ping_deadline_nxt   = ping_next_dl;
          skip_first_ping_nxt = 1'b0;
          res.send_status_request = !skip_first_ping_r;
        end else if (disc_passed) begin
          timeout_count_nxt       = count_inc;
          res.flush_receive       = 1'b1;
          res.send_status_request = 1'b1;
          res.reinit_link = cfg.reinit_enable &&
                            (count_inc == {{(COUNT_W-REINIT_W){1'b0}}, cfg.reinit_at_count});
          ping_deadline_nxt = ping_next_dl;
          disc_deadline_nxt = disc_next_dl;
        end else begin
          res.connected = 1'b1;
          if (ping_passed) begin
            res.send_status_request = 1'b1;
            ping_deadline_nxt       = ping_next_dl;
          end
        end
      end
      FUNC_RX_SEEN: begin
        ping_deadline_nxt = ping_next_dl;
        disc_deadline_nxt = disc_next_dl;
        timeout_count_nxt = '0;
      end
      FUNC_HANDSHAKE: begin
        skip_first_ping_nxt = 1'b1;
      end
      default: begin
        start_pending_nxt = start_pending_r;
      end
    endcase

    res.timeout_number = timeout_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pending_r   <= 1'b1;
      skip_first_ping_r <= 1'b0;
      ping_deadline_r   <= '0;
      disc_deadline_r   <= '0;
      timeout_count_r   <= '0;
    end else if (en) begin
      start_pending_r   <= start_pending_nxt;
      skip_first_ping_r <= skip_first_ping_nxt;
      ping_deadline_r   <= ping_deadline_nxt;
      disc_deadline_r   <= disc_deadline_nxt;
      timeout_count_r   <= timeout_count_nxt;
    end
  end

endmodule

// ===== design/lkw_checker.sv =====
// ----------------------------------------------------------------------------
// lkw_port_checker
// port-level checks on the watchdog result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkw_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        connected,
  input logic                        send_status_request,
  input logic                        flush_receive,
  input logic                        reinit_link,
  input logic [lkw_pkg::COUNT_W-1:0] timeout_number
);
  import lkw_pkg::*;

  `LKW_ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_valid)
  `LKW_ASSERT(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(timeout_number) && $stable(flush_receive))
  `LKW_ASSERT(a_timeout_not_connected, clk, rst_n, out_valid && flush_receive |-> !connected && send_status_request && timeout_number != '0)
  `LKW_ASSERT(a_reinit_on_timeout, clk, rst_n, out_valid && reinit_link |-> flush_receive)

endmodule

bind link_keepalive_watchdog lkw_port_checker u_lkw_port_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .connected           (out_ch.connected),
  .send_status_request (out_ch.send_status_request),
  .flush_receive       (out_ch.flush_receive),
  .reinit_link         (out_ch.reinit_link),
  .timeout_number      (out_ch.timeout_number)
);
